>>> design/cnv3_pkg.sv
package cnv3_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COEF_BITS = 12;
  localparam int FRAC_BITS = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int IW_W      = 13;
  localparam int CMP_W     = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
  localparam int KER_W     = 3 * COEF_BITS;
  localparam int PIX_W     = 32;
  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 4;
  localparam int TAPS      = 9;
  localparam int PROD_W    = COEF_BITS + CHAN_W + 1;
  localparam int SUM_W     = PROD_W + 4;

  localparam logic [ROW_W-1:0]  ROW_MAX         = '1;
  localparam logic [IW_W-1:0]   IMAGE_WIDTH_RST = IW_W'(640);
  localparam logic [KER_W-1:0]  KER_ZERO_RST    = '0;
  localparam logic [KER_W-1:0]  KER_HERE_RST    = KER_W'(256);
  localparam logic [CHAN_W-1:0] CHAN_MAX        = '1;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH,
    CFG_KER_LEFT2,
    CFG_KER_LEFT1,
    CFG_KER_HERE
  } cfg_reg_e;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] in_alpha;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_alpha;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } pix_out_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  // Slot 0 of a kernel register weights row y, slot 2 weights row y-2.
  function automatic logic signed [COEF_BITS-1:0] weight(input logic [KER_W-1:0] ker,
                                                        input int unsigned row);
    int unsigned slot;
    slot = 2 - row;
    return ker[slot*COEF_BITS +: COEF_BITS];
  endfunction

  // Channel 0 is alpha in the top byte, channel 3 is blue in the bottom byte.
  function automatic logic [CHAN_W-1:0] chan(input logic [PIX_W-1:0] px,
                                             input int unsigned c);
    int unsigned pos;
    pos = (NCHAN - 1 - c) * CHAN_W;
    return px[pos +: CHAN_W];
  endfunction

endpackage

>>> design/cnv3_ram.sv
module cnv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/conv3x3_argb_clamp.sv
// A result is registered in stage one, the product stage and the output stage after its pixel transfer.
// Throughput: one pixel per cycle while the output is not stalled; each line buffer is read at accept
// and written when that pixel leaves stage one, with same-column forwarding between the two.
// Reset clears the pipeline, position counters, window and registers at once.
// The line buffers are not cleared, so no clearing pass follows reset.
module conv3x3_argb_clamp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cnv3_pkg::pix_in_t        in_pix_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cnv3_pkg::pix_out_t       out_pix_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  cnv3_pkg::cfg_reg_e       cfg_index_i,
  input  logic [cnv3_pkg::KER_W-1:0] cfg_data_i
);
  import cnv3_pkg::*;

  logic [IW_W-1:0]  img_width_q;
  logic [KER_W-1:0] ker_q [3];

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [CMP_W-1:0] width_eff, col_next;
  logic [PIX_W-1:0] px_in;
  logic             acc;

  logic             out_adv, s2_ready, s1_ready, s1_adv, s2_adv;

  logic             s1_vld_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_cge1_q, s1_cge2_q, s1_rge1_q, s1_rge2_q;
  logic             fwd_hit_q;
  logic [PIX_W-1:0] fwd_px_q, fwd_above_q;

  logic [PIX_W-1:0] ram_above, ram_two, above_eff, two_eff;
  logic [PIX_W-1:0] win_q [6];

  logic             s2_vld_q;
  prod_t            s2_prod_q [NCHAN][TAPS];
  prod_t            prod_d [NCHAN][TAPS];

  logic             out_vld_q;
  pix_out_t         out_pix_q;
  logic [CHAN_W-1:0] res_d [NCHAN];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q <= IMAGE_WIDTH_RST;
      ker_q[0]    <= KER_ZERO_RST;
      ker_q[1]    <= KER_ZERO_RST;
      ker_q[2]    <= KER_HERE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: img_width_q <= cfg_data_i[IW_W-1:0];
        CFG_KER_LEFT2:   ker_q[0]    <= cfg_data_i;
        CFG_KER_LEFT1:   ker_q[1]    <= cfg_data_i;
        CFG_KER_HERE:    ker_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s2_ready   = !s2_vld_q || out_adv;
  assign s1_ready   = !s1_vld_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign acc        = in_valid_i && s1_ready;
  assign s1_adv     = s1_vld_q && s2_ready;
  assign s2_adv     = s2_vld_q && out_adv;

  assign px_in = {in_pix_i.in_alpha, in_pix_i.in_red, in_pix_i.in_green, in_pix_i.in_blue};

  always_comb begin
    col_cur   = in_pix_i.frame_start ? '0 : col_q;
    row_cur   = in_pix_i.frame_start ? '0 : row_q;
    width_eff = CMP_W'(img_width_q);
    if (width_eff == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_eff > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end
    col_next = CMP_W'(col_cur) + CMP_W'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (acc) begin
      if (col_next >= width_eff) begin
        col_d = '0;
        row_d = (row_cur < ROW_MAX) ? row_cur + ROW_W'(1) : row_cur;
      end else begin
        col_d = col_next[COL_W-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_hit_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s1_ready) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_vld_q <= s1_vld_q;
      end
      if (out_adv) begin
        out_vld_q <= s2_vld_q;
      end
      if (acc) begin
        fwd_hit_q <= s1_vld_q && (s1_col_q == col_cur);
      end
      if (s1_adv) begin
        win_q[1] <= win_q[0];
        win_q[0] <= s1_px_q;
        win_q[3] <= win_q[2];
        win_q[2] <= above_eff;
        win_q[5] <= win_q[4];
        win_q[4] <= two_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_px_q     <= px_in;
      s1_col_q    <= col_cur;
      s1_cge1_q   <= col_cur >= COL_W'(1);
      s1_cge2_q   <= col_cur >= COL_W'(2);
      s1_rge1_q   <= row_cur >= ROW_W'(1);
      s1_rge2_q   <= row_cur >= ROW_W'(2);
      fwd_px_q    <= s1_px_q;
      fwd_above_q <= above_eff;
    end
    if (s1_adv) begin
      s2_prod_q <= prod_d;
    end
    if (s2_adv) begin
      out_pix_q <= {res_d[0], res_d[1], res_d[2], res_d[3]};
    end
  end

  cnv3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_above (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(s1_px_q),
    .re_i   (acc),
    .raddr_i(col_cur),
    .rdata_o(ram_above)
  );

  cnv3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_two_above (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(above_eff),
    .re_i   (acc),
    .raddr_i(col_cur),
    .rdata_o(ram_two)
  );

  // A read that met a write to the same column at the same edge takes the written data.
  assign above_eff = fwd_hit_q ? fwd_px_q : ram_above;
  assign two_eff   = fwd_hit_q ? fwd_above_q : ram_two;

  always_comb begin
    logic [PIX_W-1:0] wpx [3][3];
    logic             cok [3];
    logic             rok [3];
    logic signed [COEF_BITS-1:0] wt;
    logic signed [CHAN_W:0]      pv;
    wpx[2][2] = s1_px_q;  wpx[2][1] = above_eff; wpx[2][0] = two_eff;
    wpx[1][2] = win_q[0]; wpx[1][1] = win_q[2];  wpx[1][0] = win_q[4];
    wpx[0][2] = win_q[1]; wpx[0][1] = win_q[3];  wpx[0][0] = win_q[5];
    cok[0] = s1_cge2_q; cok[1] = s1_cge1_q; cok[2] = 1'b1;
    rok[0] = s1_rge2_q; rok[1] = s1_rge1_q; rok[2] = 1'b1;
    for (int c = 0; c < NCHAN; c++) begin
      for (int d = 0; d < 3; d++) begin
        for (int r = 0; r < 3; r++) begin
          wt = weight(ker_q[d], r);
          pv = $signed({1'b0, chan(wpx[d][r], c)});
          if (cok[d] && rok[r]) begin
            prod_d[c][d*3+r] = pv * wt;
          end else begin
            prod_d[c][d*3+r] = '0;
          end
        end
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < NCHAN; c++) begin
      sum = '0;
      for (int k = 0; k < TAPS; k++) begin
        sum = sum + SUM_W'(s2_prod_q[c][k]);
      end
      if (sum[SUM_W-1]) begin
        res_d[c] = '0;
      end else if (|sum[SUM_W-2:FRAC_BITS+CHAN_W]) begin
        res_d[c] = CHAN_MAX;
      end else begin
        res_d[c] = sum[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pix_o   = out_pix_q;

`ifndef SYNTHESIS
  a_accept_moves_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s1_vld_q) |-> s1_adv)
    else $error("pixel accepted while stage one holds");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("transfer taken into a full pipeline");

  a_col_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (col_q == '0) || (CMP_W'(col_q) == $past(col_next)))
    else $error("column counter skipped");

  a_row_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !in_pix_i.frame_start) |=> (row_q >= $past(row_q)))
    else $error("row counter moved backward within a frame");
`endif

endmodule
